>>> rtl/core/tsprg_pkg.sv
// tsprg_pkg: shared constants for the reduced-matrix tour bound block
// no dependencies
`timescale 1ns / 1ps
package tsprg_pkg;
   localparam int          MAX_CITIES = 16;
   localparam logic [9:0]  NO_EDGE   = 10'd999;
   localparam logic [15:0] BOUND_MAX = 16'hFFFF;
   // saturating bound add
   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[16] ? BOUND_MAX : s[15:0];
   endfunction
endpackage

>>> rtl/core/tsp_reduced_matrix_greedy_bound.sv
// top level: cost matrix memory, reduction sequencer and result register
// depends on tsprg_pkg
//
// channel | direction | handshake          | payload
// req_    | in        | req_valid/req_stall| from_city to_city edge_cost solve_now
// rsp_    | out       | rsp_valid/rsp_stall| tour_step tour_city step_bound tour_done
// csr_    | in        | APB write/read     | city_count at address 0
//
// load words are written to the root matrix as they are taken; a solve word
// starts the sequencer. the solve runs on one port per matrix and one
// compare/subtract unit: each line is scanned entry by entry, an address step
// and then a data step each, subtracted the same way when it has an edge, and
// closed with a step state. each candidate adds a select state, a copy of all
// 256 root entries into the work matrix and a read of its root edge cost.
// req_stall is high during the whole solve; the sequencer pauses at an emit
// while the result register still holds a stalled word. reset is synchronous;
// memories need none.
`timescale 1ns / 1ps
module tsp_reduced_matrix_greedy_bound
   import tsprg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_from_city,
   input  logic [3:0]  req_to_city,
   input  logic [9:0]  req_edge_cost,
   input  logic        req_solve_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_tour_step,
   output logic [3:0]  rsp_tour_city,
   output logic [15:0] rsp_step_bound,
   output logic        rsp_tour_done,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int IW = (MAX_CITIES > 2) ? $clog2(MAX_CITIES) : 1;
   localparam int CW = $clog2(MAX_CITIES + 1);
   localparam int AW = 2 * IW;

   localparam logic [3:0] S_IDLE = 4'd0, S_MIN = 4'd1, S_SUB = 4'd2,
      S_NEXT = 4'd3, S_COPY = 4'd4, S_EDGE = 4'd5, S_CAND = 4'd6,
      S_PICK = 4'd7, S_EMIT = 4'd8, S_ROOTEMIT = 4'd9;

   // configuration
   logic [4:0] city_count_ff;
   assign pready = 1'b1;
   assign prdata = (paddr == 3'd0) ? {27'd0, city_count_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) city_count_ff <= 5'd16;
      else if (psel && penable && pwrite && paddr == 3'd0) city_count_ff <= pwdata[4:0];
   end

   // matrices: root and work, each one port
   logic [9:0] root_mem [MAX_CITIES*MAX_CITIES];
   logic [9:0] work_mem [MAX_CITIES*MAX_CITIES];

   logic [3:0]    st_ff;
   logic          in_work_ff;      // reduction runs on work matrix
   logic          col_ff;          // column pass
   logic [IW-1:0] line_ff, idx_ff; // line and position in line
   logic [9:0]    lo_ff;
   logic [15:0]   sum_ff;
   logic [CW-1:0] n_ff;
   logic [MAX_CITIES-1:0] vis_ff;
   logic [IW-1:0] lvl_ff, cand_ff, cur_ff;
   logic [15:0]   level_ff, best_ff;
   logic [IW-1:0] bestj_ff;
   logic          have_ff;
   logic          rdv_ff;
   logic [AW-1:0] copy_ff;
   logic          copy_done_ff;

   // result register
   logic        ov_ff;
   logic [3:0]  o_step_ff, o_city_ff;
   logic [15:0] o_bound_ff;
   logic        o_done_ff;
   assign rsp_valid = ov_ff; assign rsp_tour_step = o_step_ff;
   assign rsp_tour_city = o_city_ff; assign rsp_step_bound = o_bound_ff;
   assign rsp_tour_done = o_done_ff;

   assign req_stall = (st_ff != S_IDLE);
   wire req_take = req_valid && !req_stall;

   wire [CW-1:0] n_cl = (city_count_ff < 5'd2) ? CW'(2) :
      ({27'd0, city_count_ff} > MAX_CITIES) ? CW'(MAX_CITIES) : CW'(city_count_ff);
   wire [IW-1:0] last = IW'(n_ff - CW'(1));

   // current address: row-major unless column pass
   wire [IW-1:0] r_a = col_ff ? idx_ff : line_ff;
   wire [IW-1:0] c_a = col_ff ? line_ff : idx_ff;
   wire [AW-1:0] addr = {r_a, c_a};

   // masking applied on read of a work entry (copy writes unmasked)
   logic masked;
   always_comb begin
      masked = vis_ff[r_a] || (c_a == cand_ff) || (r_a == cand_ff && c_a == '0)
               || (vis_ff[c_a] && c_a != '0);
   end

   logic [9:0] m_rd, cur_v;
   logic [9:0] root_rd_ff, work_rd_ff;
   always_ff @(posedge clock) begin
      root_rd_ff <= root_mem[(st_ff == S_COPY) ? copy_ff :
                             (st_ff == S_EDGE) ? {cur_ff, cand_ff} : addr];
      work_rd_ff <= work_mem[addr];
   end
   assign m_rd = in_work_ff ? work_rd_ff : root_rd_ff;
   assign cur_v = m_rd;

   wire [9:0] cost_cl = (req_edge_cost > NO_EDGE || req_from_city == req_to_city)
                        ? NO_EDGE : req_edge_cost;
   wire [IW-1:0] idx_nx = idx_ff + IW'(1);
   wire idx_end = (idx_ff == last);
   wire line_end = (line_ff == last);

   // candidate bound: work reduction plus level bound plus root edge
   wire [15:0] cand_bound = sat_add(sat_add(sum_ff, level_ff), {6'd0, root_rd_ff});
   wire last_lvl = (({1'b0, lvl_ff} + CW'(2)) == n_ff);
   wire emit_go = (st_ff == S_ROOTEMIT || st_ff == S_EMIT) && (!ov_ff || !rsp_stall);

   // write ports
   always_ff @(posedge clock) begin
      if (req_take && {28'd0, req_from_city} < MAX_CITIES && {28'd0, req_to_city} < MAX_CITIES)
         root_mem[{req_from_city[IW-1:0], req_to_city[IW-1:0]}] <= cost_cl;
      else if (st_ff == S_SUB && rdv_ff && !in_work_ff && cur_v != NO_EDGE)
         root_mem[addr] <= cur_v - lo_ff;
      if (st_ff == S_COPY && copy_done_ff)
         work_mem[copy_ff - AW'(1)] <= root_rd_ff;
      else if (st_ff == S_SUB && rdv_ff && in_work_ff)
         work_mem[addr] <= (masked || cur_v == NO_EDGE) ? NO_EDGE : cur_v - lo_ff;
   end

   // effective value read during scan (mask applies to work copy)
   wire [9:0] scan_v = (in_work_ff && masked) ? NO_EDGE : cur_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ov_ff <= 1'b0; rdv_ff <= 1'b0; vis_ff <= '0;
      end else begin
         // result valid: load on emit, clear once taken
         if (emit_go) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (req_take && req_solve_now) begin
               st_ff <= S_MIN; n_ff <= n_cl; in_work_ff <= 1'b0; col_ff <= 1'b0;
               line_ff <= '0; idx_ff <= '0; lo_ff <= NO_EDGE; sum_ff <= '0;
               rdv_ff <= 1'b0; vis_ff <= MAX_CITIES'(1); cand_ff <= '0;
               lvl_ff <= '0;
            end
            // scan a line for its minimum: address cycle, then data cycle
            S_MIN: begin
               rdv_ff <= !rdv_ff;
               if (rdv_ff && scan_v < lo_ff) lo_ff <= scan_v;
               if (rdv_ff) begin
                  if (idx_end) begin
                     idx_ff <= '0;
                     st_ff <= (lo_ff == NO_EDGE && !(scan_v < lo_ff)) ? S_NEXT : S_SUB;
                  end else idx_ff <= idx_nx;
               end
            end
            // subtract minimum along the line
            S_SUB: begin
               rdv_ff <= !rdv_ff;
               if (rdv_ff) begin
                  if (idx_end) begin
                     idx_ff <= '0; st_ff <= S_NEXT;
                     sum_ff <= sat_add(sum_ff, {6'd0, lo_ff});
                  end else idx_ff <= idx_nx;
               end
            end
            S_NEXT: begin
               lo_ff <= NO_EDGE; rdv_ff <= 1'b0;
               if (!line_end) begin line_ff <= line_ff + IW'(1); st_ff <= S_MIN; end
               else if (!col_ff) begin col_ff <= 1'b1; line_ff <= '0; st_ff <= S_MIN; end
               else if (!in_work_ff) begin
                  level_ff <= sum_ff; st_ff <= S_ROOTEMIT;
               end else st_ff <= S_EDGE;
            end
            S_ROOTEMIT: if (emit_go) begin
               o_step_ff <= 4'd0; o_city_ff <= 4'd0;
               o_bound_ff <= level_ff; o_done_ff <= 1'b0;
               cur_ff <= '0; cand_ff <= '0; have_ff <= 1'b0; st_ff <= S_CAND;
            end
            // choose next unvisited candidate or finish level
            S_CAND: begin
               if (!vis_ff[cand_ff]) begin
                  st_ff <= S_COPY; copy_ff <= '0; copy_done_ff <= 1'b0;
                  in_work_ff <= 1'b0;
               end else if (cand_ff == last) st_ff <= S_PICK;
               else cand_ff <= cand_ff + IW'(1);
            end
            // copy root to work, one entry a cycle (unused rows are copied too)
            S_COPY: begin
               copy_done_ff <= 1'b1;
               copy_ff <= copy_ff + AW'(1);
               if (copy_done_ff && copy_ff == '0) begin
                  in_work_ff <= 1'b1; col_ff <= 1'b0; line_ff <= '0; idx_ff <= '0;
                  lo_ff <= NO_EDGE; sum_ff <= '0; rdv_ff <= 1'b0; st_ff <= S_MIN;
               end
            end
            // read the root edge from the current city and rate the candidate
            S_EDGE: begin
               rdv_ff <= !rdv_ff; in_work_ff <= 1'b0;
               if (rdv_ff) begin
                  if (!have_ff || cand_bound < best_ff) begin
                     best_ff <= cand_bound; bestj_ff <= cand_ff; have_ff <= 1'b1;
                  end
                  st_ff <= (cand_ff == last) ? S_PICK : S_CAND;
                  if (cand_ff != last) cand_ff <= cand_ff + IW'(1);
               end
            end
            S_PICK: begin
               vis_ff[bestj_ff] <= 1'b1; level_ff <= best_ff; st_ff <= S_EMIT;
            end
            S_EMIT: if (emit_go) begin
               o_step_ff <= 4'(lvl_ff + IW'(1)); o_city_ff <= 4'(bestj_ff);
               o_bound_ff <= level_ff;
               o_done_ff <= last_lvl;
               if (last_lvl) st_ff <= S_IDLE;
               else begin
                  lvl_ff <= lvl_ff + IW'(1); cur_ff <= bestj_ff; cand_ff <= '0;
                  have_ff <= 1'b0; st_ff <= S_CAND;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   // assertions
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> req_stall) else $error("accepted word during solve");
   a_root: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_CAND) |-> vis_ff[0]) else $error("start city not visited");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rsp_stall) |=> $stable(o_bound_ff)) else $error("result changed");
endmodule
